@@ rtl/pressure_temperature_compensation_top_macros.svh @@
// Assertion helpers shared by the compensation RTL.
`ifndef PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH
`define PRESSURE_TEMPERATURE_COMPENSATION_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PTC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ptc_pkg.sv @@
`default_nettype none

package ptc_pkg;

  localparam int unsigned CalW    = 16;
  localparam int unsigned RawW    = 24;
  localparam int unsigned DtW     = 26;
  localparam int unsigned DevW    = 18;
  localparam int unsigned SqW     = 36;
  localparam int unsigned T2W     = 17;
  localparam int unsigned SensW   = 40;
  localparam int unsigned OffW    = 40;
  localparam int unsigned CorrW   = 39;
  localparam int unsigned TempW   = 19;
  localparam int unsigned PressW  = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned TempStages  = 4;
  localparam int unsigned PressStages = 7;
  localparam int unsigned Latency     = TempStages + PressStages;
  localparam int unsigned CntW        = $clog2(Latency + 1);

  localparam logic signed [PressW-1:0] PressMax = 32'sh7FFF_FFFF;
  localparam logic signed [PressW-1:0] PressMin = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESSURE_SENS     = 3'd0,
    REG_PRESSURE_OFFSET   = 3'd1,
    REG_SENS_TEMP_COEFF   = 3'd2,
    REG_OFFSET_TEMP_COEFF = 3'd3,
    REG_REFERENCE_TEMP    = 3'd4,
    REG_TEMP_COEFF        = 3'd5
  } cal_reg_e;

  localparam logic [CfgIdxW-1:0] RegLast = REG_TEMP_COEFF;

  typedef struct packed {
    logic [CalW-1:0] pressure_sens;
    logic [CalW-1:0] pressure_offset;
    logic [CalW-1:0] sens_temp_coeff;
    logic [CalW-1:0] offset_temp_coeff;
    logic [CalW-1:0] reference_temp;
    logic [CalW-1:0] temp_coeff;
  } cal_t;

  // Hand-off from the temperature section to the pressure section.
  typedef struct packed {
    logic signed [TempW-1:0] temp;
    logic signed [SensW-1:0] sens1;
    logic signed [OffW-1:0]  off1;
    logic [SqW-1:0]          sq;
    logic [SqW-1:0]          lsq;
    logic                    below20;
    logic                    below_m15;
    logic [RawW-1:0]         d1;
  } temp_res_t;

endpackage

`default_nettype wire

@@ rtl/ptc_cal_regs.sv @@
`default_nettype none
`include "pressure_temperature_compensation_top_macros.svh"

module ptc_cal_regs (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  output      logic                         cfg_ready_o,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [ptc_pkg::CalW-1:0]     cfg_data_i,
  output      ptc_pkg::cal_t                cal_o
);

  ptc_pkg::cal_t cal_q, cal_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cal_d = cal_q;
    if (cfg_valid_i) begin
      case (ptc_pkg::cal_reg_e'(cfg_index_i))
        ptc_pkg::REG_PRESSURE_SENS:     cal_d.pressure_sens     = cfg_data_i;
        ptc_pkg::REG_PRESSURE_OFFSET:   cal_d.pressure_offset   = cfg_data_i;
        ptc_pkg::REG_SENS_TEMP_COEFF:   cal_d.sens_temp_coeff   = cfg_data_i;
        ptc_pkg::REG_OFFSET_TEMP_COEFF: cal_d.offset_temp_coeff = cfg_data_i;
        ptc_pkg::REG_REFERENCE_TEMP:    cal_d.reference_temp    = cfg_data_i;
        ptc_pkg::REG_TEMP_COEFF:        cal_d.temp_coeff        = cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  assign cal_o = cal_q;

  `PTC_ASSERT_NXT(a_bad_index_ignored, clk_i, rst_ni,
    cfg_valid_i && (cfg_index_i > ptc_pkg::RegLast), $stable(cal_q),
    "write beyond register list changed calibration")

endmodule

`default_nettype wire

@@ rtl/ptc_temp_pipe.sv @@
`default_nettype none

module ptc_temp_pipe (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ptc_pkg::cal_t              cal_i,
  input  wire logic                       in_valid_i,
  output      logic                       in_ready_o,
  input  wire logic [ptc_pkg::RawW-1:0]   raw_pressure_i,
  input  wire logic [ptc_pkg::RawW-1:0]   raw_temperature_i,
  output      logic                       res_valid_o,
  input  wire logic                       res_ready_i,
  output      ptc_pkg::temp_res_t         res_o
);

  localparam int unsigned N = ptc_pkg::TempStages;

  logic [N-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[N-1] = !vld_q[N-1] || res_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 1: temperature difference
  logic signed [ptc_pkg::DtW-1:0] s1_dt_q, s1_dt_d;
  logic [ptc_pkg::RawW-1:0]       s1_d1_q;

  assign s1_dt_d = $signed({2'b00, raw_temperature_i})
                 - $signed({2'b00, cal_i.reference_temp, 8'h00});

  // Stage 2: products of dt
  logic signed [42:0] s2_p3_q, s2_p3_d, s2_p4_q, s2_p4_d, s2_p6_q, s2_p6_d;
  logic signed [51:0] dtsq_full;
  logic [47:0]        s2_dtsq_q, s2_dtsq_d;
  logic [ptc_pkg::RawW-1:0] s2_d1_q;

  assign s2_p3_d   = $signed({1'b0, cal_i.sens_temp_coeff}) * s1_dt_q;
  assign s2_p4_d   = $signed({1'b0, cal_i.offset_temp_coeff}) * s1_dt_q;
  assign s2_p6_d   = $signed({1'b0, cal_i.temp_coeff}) * s1_dt_q;
  assign dtsq_full = s1_dt_q * s1_dt_q;
  assign s2_dtsq_d = dtsq_full[47:0];

  // Stage 3: divide toward zero, first-order sens/off/temp, T2 candidates
  logic signed [42:0] p3_adj, p4_adj, p6_adj, q3, q4, q6;
  logic [49:0] dtsq3;
  logic [50:0] dtsq7;
  logic signed [ptc_pkg::SensW-1:0] s3_sens_q, s3_sens_d;
  logic signed [ptc_pkg::OffW-1:0]  s3_off_q, s3_off_d;
  logic signed [ptc_pkg::DevW-1:0]  s3_dev_q, s3_dev_d;
  logic [ptc_pkg::T2W-1:0]          s3_t2a_q, s3_t2a_d;
  logic [13:0]                      s3_t2b_q, s3_t2b_d;
  logic [ptc_pkg::RawW-1:0]         s3_d1_q;

  assign p3_adj = s2_p3_q + (s2_p3_q[42] ? 43'sd255 : 43'sd0);
  assign p4_adj = s2_p4_q + (s2_p4_q[42] ? 43'sd127 : 43'sd0);
  assign p6_adj = s2_p6_q + (s2_p6_q[42] ? 43'sd8388607 : 43'sd0);
  assign q3 = p3_adj >>> 8;
  assign q4 = p4_adj >>> 7;
  assign q6 = p6_adj >>> 23;

  assign s3_sens_d = $signed({9'd0, cal_i.pressure_sens, 15'd0}) + 40'(q3);
  assign s3_off_d  = $signed({8'd0, cal_i.pressure_offset, 16'd0}) + 40'(q4);
  assign s3_dev_d  = 18'(q6);

  assign dtsq3    = {2'b00, s2_dtsq_q} + {1'b0, s2_dtsq_q, 1'b0};
  assign dtsq7    = {s2_dtsq_q, 3'b000} - {3'b000, s2_dtsq_q};
  assign s3_t2a_d = dtsq3[49:33];
  assign s3_t2b_d = dtsq7[50:37];

  // Stage 4: squares, range flags, final temperature
  logic signed [35:0] sq_full;
  logic signed [18:0] low;
  logic signed [37:0] lsq_full;
  logic [ptc_pkg::T2W-1:0] t2;
  logic signed [19:0] temp_full;
  ptc_pkg::temp_res_t s4_q, s4_d;

  assign sq_full   = s3_dev_q * s3_dev_q;
  assign low       = 19'(s3_dev_q) + 19'sd3500;
  assign lsq_full  = low * low;
  assign t2        = s3_dev_q[ptc_pkg::DevW-1] ? s3_t2a_q : 17'(s3_t2b_q);
  assign temp_full = 20'(s3_dev_q) + 20'sd2000 - $signed({3'b000, t2});

  always_comb begin
    s4_d.temp      = temp_full[ptc_pkg::TempW-1:0];
    s4_d.sens1     = s3_sens_q;
    s4_d.off1      = s3_off_q;
    s4_d.sq        = sq_full[ptc_pkg::SqW-1:0];
    s4_d.lsq       = lsq_full[ptc_pkg::SqW-1:0];
    s4_d.below20   = s3_dev_q[ptc_pkg::DevW-1];
    s4_d.below_m15 = s3_dev_q < -18'sd3500;
    s4_d.d1        = s3_d1_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= raw_pressure_i;
    end
    if (rdy[1]) begin
      s2_p3_q   <= s2_p3_d;
      s2_p4_q   <= s2_p4_d;
      s2_p6_q   <= s2_p6_d;
      s2_dtsq_q <= s2_dtsq_d;
      s2_d1_q   <= s1_d1_q;
    end
    if (rdy[2]) begin
      s3_sens_q <= s3_sens_d;
      s3_off_q  <= s3_off_d;
      s3_dev_q  <= s3_dev_d;
      s3_t2a_q  <= s3_t2a_d;
      s3_t2b_q  <= s3_t2b_d;
      s3_d1_q   <= s2_d1_q;
    end
    if (rdy[3]) begin
      s4_q <= s4_d;
    end
  end

  assign in_ready_o  = rdy[0];
  assign res_valid_o = vld_q[N-1];
  assign res_o       = s4_q;

endmodule

`default_nettype wire

@@ rtl/ptc_press_pipe.sv @@
`default_nettype none

module ptc_press_pipe (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                res_valid_i,
  output      logic                                res_ready_o,
  input  wire ptc_pkg::temp_res_t                  res_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [ptc_pkg::TempW-1:0]    temperature_centi_o,
  output      logic signed [ptc_pkg::PressW-1:0]   pressure_deci_mbar_o
);

  localparam int unsigned N = ptc_pkg::PressStages;

  logic [N-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[N-1] = !vld_q[N-1] || out_ready_i;
    for (int k = N - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? res_valid_i : vld_q[0];
    for (int k = 1; k < N; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage 5: second-order offset and sensitivity corrections
  logic [37:0] sq3, sq5, lsq4;
  logic [38:0] lsq7;
  logic [ptc_pkg::CorrW-1:0] s5_off2_q, s5_off2_d, s5_sens2_q, s5_sens2_d;
  logic signed [ptc_pkg::SensW-1:0] s5_sens1_q;
  logic signed [ptc_pkg::OffW-1:0]  s5_off1_q;
  logic signed [ptc_pkg::TempW-1:0] s5_temp_q;
  logic [ptc_pkg::RawW-1:0]         s5_d1_q;

  assign sq3  = {2'b00, res_i.sq} + {1'b0, res_i.sq, 1'b0};
  assign sq5  = {2'b00, res_i.sq} + {res_i.sq, 2'b00};
  assign lsq4 = {res_i.lsq, 2'b00};
  assign lsq7 = {res_i.lsq, 3'b000} - {3'b000, res_i.lsq};

  always_comb begin
    if (res_i.below20) begin
      s5_off2_d  = 39'(sq3[37:1]) + (res_i.below_m15 ? lsq7 : 39'd0);
      s5_sens2_d = 39'(sq5[37:3]) + (res_i.below_m15 ? 39'(lsq4) : 39'd0);
    end else begin
      s5_off2_d  = 39'(res_i.sq[ptc_pkg::SqW-1:4]);
      s5_sens2_d = '0;
    end
  end

  // Stage 6: apply corrections
  logic signed [ptc_pkg::SensW-1:0] s6_sens_q, s6_sens_d;
  logic signed [ptc_pkg::OffW-1:0]  s6_off_q, s6_off_d;
  logic signed [ptc_pkg::TempW-1:0] s6_temp_q;
  logic [ptc_pkg::RawW-1:0]         s6_d1_q;

  assign s6_sens_d = s5_sens1_q - $signed({1'b0, s5_sens2_q});
  assign s6_off_d  = s5_off1_q - $signed({1'b0, s5_off2_q});

  // Stage 7: D1 * SENS as two partial products
  logic [43:0]        s7_lo_q, s7_lo_d;
  logic signed [44:0] s7_hi_q, s7_hi_d;
  logic signed [ptc_pkg::OffW-1:0]  s7_off_q;
  logic signed [ptc_pkg::TempW-1:0] s7_temp_q;

  assign s7_lo_d = s6_d1_q * s6_sens_q[19:0];
  assign s7_hi_d = $signed({1'b0, s6_d1_q}) * $signed(s6_sens_q[39:20]);

  // Stage 8: merge partial products
  logic signed [63:0] s8_prod_q, s8_prod_d;
  logic signed [ptc_pkg::OffW-1:0]  s8_off_q;
  logic signed [ptc_pkg::TempW-1:0] s8_temp_q;

  assign s8_prod_d = (64'(s7_hi_q) <<< 20) + $signed({20'd0, s7_lo_q});

  // Stage 9: divide by 2^21 toward zero
  logic signed [63:0] prod_adj;
  logic signed [42:0] s9_x_q, s9_x_d;
  logic signed [ptc_pkg::OffW-1:0]  s9_off_q;
  logic signed [ptc_pkg::TempW-1:0] s9_temp_q;

  assign prod_adj = s8_prod_q + (s8_prod_q[63] ? 64'sd2097151 : 64'sd0);
  assign s9_x_d   = 43'(prod_adj >>> 21);

  // Stage 10: subtract offset
  logic signed [43:0] s10_y_q, s10_y_d;
  logic signed [ptc_pkg::TempW-1:0] s10_temp_q;

  assign s10_y_d = 44'(s9_x_q) - 44'(s9_off_q);

  // Stage 11: divide by 2^15 toward zero, saturate, output register
  logic signed [43:0] y_adj, z;
  logic signed [ptc_pkg::PressW-1:0] s11_p_q, s11_p_d;
  logic signed [ptc_pkg::TempW-1:0]  s11_temp_q;

  assign y_adj = s10_y_q + (s10_y_q[43] ? 44'sd32767 : 44'sd0);
  assign z     = y_adj >>> 15;

  always_comb begin
    if (z > 44'(ptc_pkg::PressMax)) begin
      s11_p_d = ptc_pkg::PressMax;
    end else if (z < 44'(ptc_pkg::PressMin)) begin
      s11_p_d = ptc_pkg::PressMin;
    end else begin
      s11_p_d = z[ptc_pkg::PressW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s5_off2_q  <= s5_off2_d;
      s5_sens2_q <= s5_sens2_d;
      s5_sens1_q <= res_i.sens1;
      s5_off1_q  <= res_i.off1;
      s5_temp_q  <= res_i.temp;
      s5_d1_q    <= res_i.d1;
    end
    if (rdy[1]) begin
      s6_sens_q <= s6_sens_d;
      s6_off_q  <= s6_off_d;
      s6_temp_q <= s5_temp_q;
      s6_d1_q   <= s5_d1_q;
    end
    if (rdy[2]) begin
      s7_lo_q   <= s7_lo_d;
      s7_hi_q   <= s7_hi_d;
      s7_off_q  <= s6_off_q;
      s7_temp_q <= s6_temp_q;
    end
    if (rdy[3]) begin
      s8_prod_q <= s8_prod_d;
      s8_off_q  <= s7_off_q;
      s8_temp_q <= s7_temp_q;
    end
    if (rdy[4]) begin
      s9_x_q    <= s9_x_d;
      s9_off_q  <= s8_off_q;
      s9_temp_q <= s8_temp_q;
    end
    if (rdy[5]) begin
      s10_y_q    <= s10_y_d;
      s10_temp_q <= s9_temp_q;
    end
    if (rdy[6]) begin
      s11_p_q    <= s11_p_d;
      s11_temp_q <= s10_temp_q;
    end
  end

  assign res_ready_o          = rdy[0];
  assign out_valid_o          = vld_q[N-1];
  assign temperature_centi_o  = s11_temp_q;
  assign pressure_deci_mbar_o = s11_p_q;

endmodule

`default_nettype wire

@@ rtl/pressure_temperature_compensation_top.sv @@
// Second-order compensation of a barometric sensor conversion pair.
// Input channel (in_valid_i / in_ready_o): one transfer carries a raw 24-bit
// pressure and a raw 24-bit temperature conversion. Output channel
// (out_valid_o / out_ready_i): one transfer per input carries the temperature
// in 0.01 degC (19-bit signed) and the pressure in 0.1 mbar (32-bit signed,
// saturated). Results leave in input order.
// Configuration channel (cfg_valid_i / cfg_ready_o): writes one of six 16-bit
// calibration words by index; cfg_ready_o is always high, indexes above five
// are dropped. Write calibration only while no item is in flight.
// Each input transfer passes through the 11-stage pipeline (four
// temperature stages, seven pressure stages, with the 24x40 pressure
// product split over two stages) before its output is valid.
// Throughput: one item per cycle while out_ready_i is high; every stage
// holds a valid bit and advances when the next stage is empty or advancing.
// Reset clears all valid bits and the calibration words to zero.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// drops in_ready_o only once all 11 stages hold an item.
`default_nettype none
`include "pressure_temperature_compensation_top_macros.svh"

module pressure_temperature_compensation_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [ptc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [ptc_pkg::CalW-1:0]            cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire logic [ptc_pkg::RawW-1:0]            raw_pressure_i,
  input  wire logic [ptc_pkg::RawW-1:0]            raw_temperature_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      logic signed [ptc_pkg::TempW-1:0]    temperature_centi_o,
  output      logic signed [ptc_pkg::PressW-1:0]   pressure_deci_mbar_o
);

  ptc_pkg::cal_t      cal;
  ptc_pkg::temp_res_t mid_res;
  logic               mid_valid, mid_ready;

  // Calibration register file
  ptc_cal_regs u_cal_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cal_o       (cal)
  );

  // Temperature, first-order pressure terms and squares
  ptc_temp_pipe u_temp_pipe (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cal_i             (cal),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_pressure_i    (raw_pressure_i),
    .raw_temperature_i (raw_temperature_i),
    .res_valid_o       (mid_valid),
    .res_ready_i       (mid_ready),
    .res_o             (mid_res)
  );

  // Second-order correction and pressure
  ptc_press_pipe u_press_pipe (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .res_valid_i          (mid_valid),
    .res_ready_o          (mid_ready),
    .res_i                (mid_res),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .temperature_centi_o  (temperature_centi_o),
    .pressure_deci_mbar_o (pressure_deci_mbar_o)
  );

  // Track items in flight for the checks below
  logic                      in_xfer, out_xfer;
  logic [ptc_pkg::CntW-1:0]  cnt_q, cnt_d;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign cnt_d    = cnt_q + ptc_pkg::CntW'(in_xfer) - ptc_pkg::CntW'(out_xfer);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `PTC_ASSERT_IMP(a_inflight_bound, clk_i, rst_ni,
    1'b1, cnt_q <= ptc_pkg::CntW'(ptc_pkg::Latency),
    "more items in flight than pipeline stages")

  `PTC_ASSERT_IMP(a_empty_no_output, clk_i, rst_ni,
    cnt_q == '0, !out_valid_o,
    "output valid with no item in flight")

  `PTC_ASSERT_IMP(a_full_backpressure, clk_i, rst_ni,
    (cnt_q == ptc_pkg::CntW'(ptc_pkg::Latency)) && !out_ready_i, !in_ready_o,
    "input ready while pipeline full and output stalled")

endmodule

`default_nettype wire
